### sv/midi_tep_pkg.sv
// ----------------------------------------------------------------------------
// midi_tep_pkg
// shared widths, event kind codes and byte constants for the track parser
// ----------------------------------------------------------------------------
package midi_tep_pkg;

  localparam int unsigned VLQ_W = 28;

  typedef logic [3:0]       kind_t;
  typedef logic [VLQ_W-1:0] vlq_t;

  // event kind codes
  localparam kind_t KIND_NOTE_OFF  = 4'd0;
  localparam kind_t KIND_NOTE_ON   = 4'd1;
  localparam kind_t KIND_SYSEX     = 4'd7;
  localparam kind_t KIND_META      = 4'd8;
  localparam kind_t KIND_EOT       = 4'd9;
  localparam kind_t KIND_STRAY     = 4'd10;
  localparam kind_t KIND_TRUNC     = 4'd11;
  localparam kind_t KIND_OVERLONG  = 4'd12;

  // status and meta bytes
  localparam logic [7:0] ST_SYSEX      = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC  = 8'hF7;
  localparam logic [7:0] ST_META       = 8'hFF;
  localparam logic [7:0] META_END_TRK  = 8'h2F;
  localparam logic [3:0] HI_NOTE_ON    = 4'h9;
  localparam logic [3:0] HI_PROGRAM    = 4'hC;
  localparam logic [3:0] HI_CHAN_PRESS = 4'hD;
  localparam logic [3:0] HI_CHAN_BASE  = 4'h8;

  // a length number may take at most this many bytes
  localparam logic [2:0] VLQ_MAX_BYTES = 3'd4;

endpackage

### sv/midi_track_event_parser.sv
// ----------------------------------------------------------------------------
// midi_track_event_parser
// byte-wide track event decoder for standard midi file track data
// ----------------------------------------------------------------------------
// usage
//   in_*  : one track byte per request, with track_start on the first byte
//           of a track and last_byte on its final byte
//   out_* : one decoded event per complete event, or an error event
//           (stray byte, truncation, overlong length number)
//   the parser state updates at the edge that accepts the byte; with the
//   result register free the event completed by a byte shows on out_* in the
//   cycle after that byte is taken
//   throughput is one byte per cycle while in_ready is high, set by the
//   combinational decode of the state register against the incoming byte
//   a stalled receiver keeps its event in the result register and one more
//   event in a skid register behind it; in_ready comes only from the skid
//   register and drops while it is occupied, until out_ready drains a slot
//   reset (rst_n low, synchronous) clears all parser state, running status
//   and the end-of-track flag, and empties both result slots
//   after an end-of-track meta event, bytes are swallowed until track_start
// ----------------------------------------------------------------------------
module midi_track_event_parser
  import midi_tep_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // byte channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_track_start,
  input  logic        in_last_byte,
  // event channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_event_kind,
  output logic [3:0]  out_channel,
  output logic [6:0]  out_data1,
  output logic [6:0]  out_data2,
  output logic [27:0] out_delta_ticks,
  output logic [7:0]  out_meta_kind,
  output logic [27:0] out_payload_length,
  output logic [31:0] out_payload_value
);

  // parse phases
  localparam logic [2:0] PH_DELTA   = 3'd0;
  localparam logic [2:0] PH_STATUS  = 3'd1;
  localparam logic [2:0] PH_DATA1   = 3'd2;
  localparam logic [2:0] PH_DATA2   = 3'd3;
  localparam logic [2:0] PH_SYSLEN  = 3'd4;
  localparam logic [2:0] PH_MTYPE   = 3'd5;
  localparam logic [2:0] PH_MLEN    = 3'd6;
  localparam logic [2:0] PH_PAYLOAD = 3'd7;

  // one event as it sits in a result slot
  typedef struct packed {
    kind_t       kind;
    logic [3:0]  ch;
    logic [6:0]  d1;
    logic [6:0]  d2;
    vlq_t        dt;
    logic [7:0]  mk;
    vlq_t        plen;
    logic [31:0] pval;
  } result_t;

  // parser state
  logic [2:0]  phase_r,     phase_nxt;
  logic [7:0]  run_st_r,    run_st_nxt;
  vlq_t        delta_r,     delta_nxt;
  logic [2:0]  vcnt_r,      vcnt_nxt;
  logic [7:0]  ev_st_r,     ev_st_nxt;
  logic [6:0]  d1_r,        d1_nxt;
  logic [7:0]  mtype_r,     mtype_nxt;
  vlq_t        len_r,       len_nxt;
  vlq_t        remain_r,    remain_nxt;
  logic [31:0] pay_r,       pay_nxt;
  logic [2:0]  pidx_r,      pidx_nxt;   // payload byte index, saturates at 4
  logic        ended_r,     ended_nxt;

  // result register and skid register
  logic        out_valid_r,  out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  result_t     res_r;
  result_t     skid_r;
  result_t     res_new;
  logic        load_res;
  logic        load_skid;
  logic        res_from_skid;
  kind_t       o_kind;
  logic [3:0]  o_ch;
  logic [6:0]  o_d1;
  logic [6:0]  o_d2;
  vlq_t        o_dt;
  logic [7:0]  o_mk;
  vlq_t        o_plen;
  logic [31:0] o_pval;

  // decode scratch
  logic        emit;
  logic        restart;
  logic        in_acc;
  logic [7:0]  b;
  logic [3:0]  hi;
  logic [2:0]  cnt_inc;
  vlq_t        vlq_shift;
  vlq_t        len_shift;

  assign in_ready = !skid_valid_r;
  assign in_acc   = in_valid && in_ready;
  assign b        = in_data_byte;
  assign res_new  = {o_kind, o_ch, o_d1, o_d2, o_dt, o_mk, o_plen, o_pval};

  always_comb begin
    phase_nxt  = phase_r;
    run_st_nxt = run_st_r;
    delta_nxt  = delta_r;
    vcnt_nxt   = vcnt_r;
    ev_st_nxt  = ev_st_r;
    d1_nxt     = d1_r;
    mtype_nxt  = mtype_r;
    len_nxt    = len_r;
    remain_nxt = remain_r;
    pay_nxt    = pay_r;
    pidx_nxt   = pidx_r;
    ended_nxt  = ended_r;
    emit       = 1'b0;
    restart    = 1'b0;
    o_kind     = KIND_NOTE_OFF;
    o_ch       = '0;
    o_d1       = '0;
    o_d2       = '0;
    o_dt       = '0;
    o_mk       = '0;
    o_plen     = '0;
    o_pval     = '0;
    hi         = '0;
    cnt_inc    = '0;
    vlq_shift  = '0;
    len_shift  = '0;

    if (in_acc) begin
      // track start wipes everything before the byte is looked at
      if (in_track_start) begin
        phase_nxt  = PH_DELTA;
        run_st_nxt = '0;
        delta_nxt  = '0;
        vcnt_nxt   = '0;
        ev_st_nxt  = '0;
        d1_nxt     = '0;
        mtype_nxt  = '0;
        len_nxt    = '0;
        remain_nxt = '0;
        pay_nxt    = '0;
        pidx_nxt   = '0;
        ended_nxt  = 1'b0;
      end

      if (!ended_nxt) begin
        hi        = ev_st_nxt[7:4];
        cnt_inc   = vcnt_nxt + 3'd1;
        vlq_shift = {delta_nxt[VLQ_W-8:0], b[6:0]};
        len_shift = {len_nxt[VLQ_W-8:0], b[6:0]};

        case (phase_nxt)
          PH_DELTA: begin
            delta_nxt = vlq_shift;
            if (b[7]) begin
              vcnt_nxt = cnt_inc;
              if (cnt_inc >= VLQ_MAX_BYTES) begin
                emit    = 1'b1;
                o_kind  = KIND_OVERLONG;
                restart = 1'b1;
              end
            end else begin
              vcnt_nxt  = '0;
              phase_nxt = PH_STATUS;
            end
          end

          PH_STATUS: begin
            if (!b[7]) begin
              if (run_st_nxt == '0) begin
                emit    = 1'b1;
                o_kind  = KIND_STRAY;
                restart = 1'b1;
              end else begin
                // running status: this byte is the first data byte
                ev_st_nxt = run_st_nxt;
                d1_nxt    = b[6:0];
                if (run_st_nxt[7:4] == HI_PROGRAM || run_st_nxt[7:4] == HI_CHAN_PRESS)
                begin
                  emit    = 1'b1;
                  o_kind  = kind_t'(run_st_nxt[7:4] - HI_CHAN_BASE);
                  o_ch    = run_st_nxt[3:0];
                  o_d1    = b[6:0];
                  o_dt    = delta_nxt;
                  restart = 1'b1;
                end else begin
                  phase_nxt = PH_DATA2;
                end
              end
            end else if (b[7:4] != 4'hF) begin
              run_st_nxt = b;
              ev_st_nxt  = b;
              phase_nxt  = PH_DATA1;
            end else begin
              run_st_nxt = '0;
              ev_st_nxt  = b;
              if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
                phase_nxt = PH_SYSLEN;
              end else if (b == ST_META) begin
                phase_nxt = PH_MTYPE;
              end else begin
                emit    = 1'b1;
                o_kind  = KIND_STRAY;
                restart = 1'b1;
              end
            end
          end

          PH_DATA1: begin
            if (b[7]) begin
              emit    = 1'b1;
              o_kind  = KIND_STRAY;
              restart = 1'b1;
            end else begin
              d1_nxt = b[6:0];
              if (hi == HI_PROGRAM || hi == HI_CHAN_PRESS) begin
                emit    = 1'b1;
                o_kind  = kind_t'(hi - HI_CHAN_BASE);
                o_ch    = ev_st_nxt[3:0];
                o_d1    = b[6:0];
                o_dt    = delta_nxt;
                restart = 1'b1;
              end else begin
                phase_nxt = PH_DATA2;
              end
            end
          end

          PH_DATA2: begin
            emit    = 1'b1;
            restart = 1'b1;
            if (b[7]) begin
              o_kind = KIND_STRAY;
            end else begin
              // note-on at zero velocity reads as note-off
              if (hi == HI_NOTE_ON && b[6:0] == '0) begin
                o_kind = KIND_NOTE_OFF;
              end else begin
                o_kind = kind_t'(hi - HI_CHAN_BASE);
              end
              o_ch = ev_st_nxt[3:0];
              o_d1 = d1_nxt;
              o_d2 = b[6:0];
              o_dt = delta_nxt;
            end
          end

          PH_SYSLEN, PH_MLEN: begin
            len_nxt = len_shift;
            if (b[7]) begin
              vcnt_nxt = cnt_inc;
              if (cnt_inc >= VLQ_MAX_BYTES) begin
                emit    = 1'b1;
                o_kind  = KIND_OVERLONG;
                restart = 1'b1;
              end
            end else begin
              vcnt_nxt = '0;
              if (len_shift == '0) begin
                // empty payload: event completes right here
                emit    = 1'b1;
                restart = 1'b1;
                o_dt    = delta_nxt;
                o_plen  = '0;
                o_pval  = pay_nxt;
                if (ev_st_nxt == ST_META) begin
                  o_mk = mtype_nxt;
                  if (mtype_nxt == META_END_TRK) begin
                    o_kind    = KIND_EOT;
                    ended_nxt = 1'b1;
                  end else begin
                    o_kind = KIND_META;
                  end
                end else begin
                  o_kind = KIND_SYSEX;
                end
              end else begin
                remain_nxt = len_shift;
                phase_nxt  = PH_PAYLOAD;
              end
            end
          end

          PH_MTYPE: begin
            mtype_nxt = b;
            vcnt_nxt  = '0;
            phase_nxt = PH_MLEN;
          end

          PH_PAYLOAD: begin
            // keep the first four payload bytes, big-endian
            case (pidx_nxt)
              3'd0:    pay_nxt[31:24] = b;
              3'd1:    pay_nxt[23:16] = b;
              3'd2:    pay_nxt[15:8]  = b;
              3'd3:    pay_nxt[7:0]   = b;
              default: pay_nxt        = pay_nxt;
            endcase
            if (pidx_nxt != VLQ_MAX_BYTES) begin
              pidx_nxt = pidx_nxt + 3'd1;
            end
            remain_nxt = remain_nxt - vlq_t'(1);
            if (remain_nxt == '0) begin
              emit    = 1'b1;
              restart = 1'b1;
              o_dt    = delta_nxt;
              o_plen  = len_nxt;
              o_pval  = pay_nxt;
              if (ev_st_nxt == ST_META) begin
                o_mk = mtype_nxt;
                if (mtype_nxt == META_END_TRK) begin
                  o_kind    = KIND_EOT;
                  ended_nxt = 1'b1;
                end else begin
                  o_kind = KIND_META;
                end
              end else begin
                o_kind = KIND_SYSEX;
              end
            end
          end

          default: begin
            restart = 1'b1;
          end
        endcase

        if (restart) begin
          phase_nxt  = PH_DELTA;
          delta_nxt  = '0;
          vcnt_nxt   = '0;
          ev_st_nxt  = '0;
          d1_nxt     = '0;
          mtype_nxt  = '0;
          len_nxt    = '0;
          remain_nxt = '0;
          pay_nxt    = '0;
          pidx_nxt   = '0;
        end

        // final byte: report an unfinished event, then drop partial state
        if (in_last_byte) begin
          if (!emit && (phase_nxt != PH_DELTA || vcnt_nxt != '0)) begin
            emit   = 1'b1;
            o_kind = KIND_TRUNC;
            o_ch   = '0;
            o_d1   = '0;
            o_d2   = '0;
            o_dt   = '0;
            o_mk   = '0;
            o_plen = '0;
            o_pval = '0;
          end
          phase_nxt  = PH_DELTA;
          delta_nxt  = '0;
          vcnt_nxt   = '0;
          ev_st_nxt  = '0;
          d1_nxt     = '0;
          mtype_nxt  = '0;
          len_nxt    = '0;
          remain_nxt = '0;
          pay_nxt    = '0;
          pidx_nxt   = '0;
        end
      end
    end
  end

  // result register takes a new event when free or draining, else the
  // event goes to the skid register and moves up once the receiver drains
  always_comb begin
    res_from_skid  = skid_valid_r && out_ready;
    load_res       = res_from_skid || (in_acc && emit && (!out_valid_r || out_ready));
    load_skid      = in_acc && emit && out_valid_r && !out_ready;
    out_valid_nxt  = load_res || (out_valid_r && !out_ready);
    skid_valid_nxt = load_skid || (skid_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_DELTA;
      run_st_r     <= '0;
      delta_r      <= '0;
      vcnt_r       <= '0;
      ev_st_r      <= '0;
      d1_r         <= '0;
      mtype_r      <= '0;
      len_r        <= '0;
      remain_r     <= '0;
      pay_r        <= '0;
      pidx_r       <= '0;
      ended_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      run_st_r     <= run_st_nxt;
      delta_r      <= delta_nxt;
      vcnt_r       <= vcnt_nxt;
      ev_st_r      <= ev_st_nxt;
      d1_r         <= d1_nxt;
      mtype_r      <= mtype_nxt;
      len_r        <= len_nxt;
      remain_r     <= remain_nxt;
      pay_r        <= pay_nxt;
      pidx_r       <= pidx_nxt;
      ended_r      <= ended_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (load_res) begin
      res_r <= res_from_skid ? skid_r : res_new;
    end
    if (load_skid) begin
      skid_r <= res_new;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_kind     = res_r.kind;
  assign out_channel        = res_r.ch;
  assign out_data1          = res_r.d1;
  assign out_data2          = res_r.d2;
  assign out_delta_ticks    = res_r.dt;
  assign out_meta_kind      = res_r.mk;
  assign out_payload_length = res_r.plen;
  assign out_payload_value  = res_r.pval;

endmodule
